FILE: rtl/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg
// shared widths, constants and types of the ray versus box slab test
// ----------------------------------------------------------------------------
package rbst_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W         = 32;
	localparam int BND_W     = W + 1;                // box bound, full width
	localparam int DEL_W     = W + 2;                // bound minus origin
	localparam int NUM_W     = DEL_W + FRAC_BITS;    // scaled numerator magnitude
	localparam int QB        = W;                    // quotient bits computed
	localparam int DIV_LAT   = QB + 2;               // divider latency in cycles
	localparam int EPS_W     = 31;
	localparam int AXES      = 3;

	localparam logic [EPS_W-1:0]  EPS_RESET = EPS_W'(66);
	localparam logic signed [W-1:0] T_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] T_MIN = {1'b1, {(W-1){1'b0}}};

	// per item side information that runs beside the dividers
	typedef struct packed {
		logic [AXES-1:0] par;     // axis counts as parallel
		logic            pmiss;   // some parallel axis has the origin outside its slab
	} side_t;

endpackage

FILE: rtl/ray_box_slab_test_core.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test_core
// ray versus axis-aligned box slab test, signed fixed point
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready): one ray and one box per transaction,
//   origin, direction, box center and half extent, all signed Q16.16
//   output channel (out_valid / out_ready): hit flag, t_near, t_far; on a
//   miss both parameters read as the most negative value
//   config channel (cfg_valid / cfg_ready): writes parallel_epsilon; always
//   ready, write it only while the pipe is empty
// timing
//   one transaction enters per cycle while the output is not stalled; the
//   result is registered through two bound/delta stages, a pipelined divider
//   that retires one quotient bit per stage, and three compare stages
//   six dividers run in parallel, two per axis, so throughput is one per cycle
// reset
//   arst_n clears all valid bits and loads parallel_epsilon with 66
// stall
//   the whole pipe advances on one enable; when the output holds a result
//   that is not taken, every stage freezes and in_ready drops, so nothing is
//   lost or repeated
// ----------------------------------------------------------------------------
module ray_box_slab_test_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [30:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [31:0]    origin_x,
	input  logic signed [31:0]    origin_y,
	input  logic signed [31:0]    origin_z,
	input  logic signed [31:0]    dir_x,
	input  logic signed [31:0]    dir_y,
	input  logic signed [31:0]    dir_z,
	input  logic signed [31:0]    center_x,
	input  logic signed [31:0]    center_y,
	input  logic signed [31:0]    center_z,
	input  logic signed [31:0]    half_x,
	input  logic signed [31:0]    half_y,
	input  logic signed [31:0]    half_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  hit,
	output logic signed [31:0]    t_near,
	output logic signed [31:0]    t_far
);

	localparam int W     = rbst_pkg::W;
	localparam int AXES  = rbst_pkg::AXES;
	localparam int LAT   = rbst_pkg::DIV_LAT;

	logic en;

	// epsilon register
	logic [rbst_pkg::EPS_W-1:0] eps_q;

	// input vectors by axis
	logic signed [W-1:0] org_in [0:AXES-1];
	logic signed [W-1:0] dir_in [0:AXES-1];
	logic signed [W-1:0] ctr_in [0:AXES-1];
	logic signed [W-1:0] hlf_in [0:AXES-1];

	// stage 1: bounds and parallel flag
	logic                            vld_s1;
	logic signed [rbst_pkg::BND_W-1:0] bmin_s1 [0:AXES-1];
	logic signed [rbst_pkg::BND_W-1:0] bmax_s1 [0:AXES-1];
	logic signed [W-1:0]             org_s1  [0:AXES-1];
	logic signed [W-1:0]             dir_s1  [0:AXES-1];
	logic [AXES-1:0]                 par_s1;

	// stage 2: numerator and divisor magnitudes
	logic                            vld_s2;
	logic [rbst_pkg::NUM_W-1:0]      nlo_s2 [0:AXES-1];
	logic [rbst_pkg::NUM_W-1:0]      nhi_s2 [0:AXES-1];
	logic                            neglo_s2 [0:AXES-1];
	logic                            neghi_s2 [0:AXES-1];
	logic [W-1:0]                    den_s2 [0:AXES-1];
	rbst_pkg::side_t                 side_s2;

	// side line beside the dividers
	logic                            vld_sd  [0:LAT-1];
	rbst_pkg::side_t                 side_sd [0:LAT-1];

	logic signed [W-1:0]             qlo [0:AXES-1];
	logic signed [W-1:0]             qhi [0:AXES-1];

	// stage 3: ordered pair per axis
	logic                            vld_s3;
	logic signed [W-1:0]             near_s3 [0:AXES-1];
	logic signed [W-1:0]             far_s3  [0:AXES-1];
	logic                            pmiss_s3;

	// stage 4: partial narrowing
	logic                            vld_s4;
	logic signed [W-1:0]             loa_s4, lob_s4, hia_s4, hib_s4;
	logic                            pmiss_s4;

	// stage 5: output register
	logic                            vld_s5;
	logic                            hit_s5;
	logic signed [W-1:0]             near_s5, far_s5;

	logic signed [W-1:0]             lo_fin, hi_fin;

	assign en        = !vld_s5 || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= rbst_pkg::EPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			eps_q <= cfg_data;
		end
	end

	assign org_in = '{origin_x, origin_y, origin_z};
	assign dir_in = '{dir_x, dir_y, dir_z};
	assign ctr_in = '{center_x, center_y, center_z};
	assign hlf_in = '{half_x, half_y, half_z};

	// valid bits of the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_sd[LAT-1];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		logic [W-1:0]                    dmag;
		logic signed [rbst_pkg::DEL_W-1:0] dlo, dhi;
		logic [rbst_pkg::DEL_W-1:0]      mlo, mhi;

		// direction magnitude; zero always counts as parallel
		assign dmag = dir_in[a][W-1] ? W'(-dir_in[a]) : dir_in[a];

		always_ff @(posedge clk) begin
			if (en) begin
				bmin_s1[a] <= rbst_pkg::BND_W'(ctr_in[a]) - rbst_pkg::BND_W'(hlf_in[a]);
				bmax_s1[a] <= rbst_pkg::BND_W'(ctr_in[a]) + rbst_pkg::BND_W'(hlf_in[a]);
				org_s1[a]  <= org_in[a];
				dir_s1[a]  <= dir_in[a];
				par_s1[a]  <= (dmag == '0) || (dmag < {1'b0, eps_q});
			end
		end

		assign dlo = rbst_pkg::DEL_W'(bmin_s1[a]) - rbst_pkg::DEL_W'(org_s1[a]);
		assign dhi = rbst_pkg::DEL_W'(bmax_s1[a]) - rbst_pkg::DEL_W'(org_s1[a]);
		assign mlo = dlo[rbst_pkg::DEL_W-1] ? rbst_pkg::DEL_W'(-dlo) : dlo;
		assign mhi = dhi[rbst_pkg::DEL_W-1] ? rbst_pkg::DEL_W'(-dhi) : dhi;

		always_ff @(posedge clk) begin
			if (en) begin
				nlo_s2[a]   <= {mlo, {rbst_pkg::FRAC_BITS{1'b0}}};
				nhi_s2[a]   <= {mhi, {rbst_pkg::FRAC_BITS{1'b0}}};
				neglo_s2[a] <= dlo[rbst_pkg::DEL_W-1] ^ dir_s1[a][W-1];
				neghi_s2[a] <= dhi[rbst_pkg::DEL_W-1] ^ dir_s1[a][W-1];
				den_s2[a]   <= dir_s1[a][W-1] ? W'(-dir_s1[a]) : dir_s1[a];
			end
		end

		rbst_div u_div_lo (
			.clk     (clk),
			.en      (en),
			.num_mag (nlo_s2[a]),
			.den_mag (den_s2[a]),
			.neg     (neglo_s2[a]),
			.quo     (qlo[a])
		);

		rbst_div u_div_hi (
			.clk     (clk),
			.en      (en),
			.num_mag (nhi_s2[a]),
			.den_mag (den_s2[a]),
			.neg     (neghi_s2[a]),
			.quo     (qhi[a])
		);

		// parallel axes leave the interval as it is
		always_ff @(posedge clk) begin
			if (en) begin
				if (side_sd[LAT-1].par[a]) begin
					near_s3[a] <= '0;
					far_s3[a]  <= rbst_pkg::T_MAX;
				end else if (qlo[a] > qhi[a]) begin
					near_s3[a] <= qhi[a];
					far_s3[a]  <= qlo[a];
				end else begin
					near_s3[a] <= qlo[a];
					far_s3[a]  <= qhi[a];
				end
			end
		end
	end

	// origin outside a parallel slab
	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.par   <= par_s1;
			side_s2.pmiss <= (par_s1[0] && ((rbst_pkg::BND_W'(org_s1[0]) < bmin_s1[0]) ||
			                                (rbst_pkg::BND_W'(org_s1[0]) > bmax_s1[0]))) ||
			                 (par_s1[1] && ((rbst_pkg::BND_W'(org_s1[1]) < bmin_s1[1]) ||
			                                (rbst_pkg::BND_W'(org_s1[1]) > bmax_s1[1]))) ||
			                 (par_s1[2] && ((rbst_pkg::BND_W'(org_s1[2]) < bmin_s1[2]) ||
			                                (rbst_pkg::BND_W'(org_s1[2]) > bmax_s1[2])));
		end
	end

	// side line, matched to the divider latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_sd[k] <= 1'b0;
			end
		end else if (en) begin
			vld_sd[0] <= vld_s2;
			for (int k = 1; k < LAT; k++) begin
				vld_sd[k] <= vld_sd[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sd[0] <= side_s2;
			for (int k = 1; k < LAT; k++) begin
				side_sd[k] <= side_sd[k-1];
			end
			pmiss_s3 <= side_sd[LAT-1].pmiss;
		end
	end

	// first half of the narrowing; the interval starts at [0, max]
	always_ff @(posedge clk) begin
		if (en) begin
			loa_s4   <= (near_s3[0] > near_s3[1]) ? near_s3[0] : near_s3[1];
			lob_s4   <= (near_s3[2] > 0) ? near_s3[2] : '0;
			hia_s4   <= (far_s3[0] < far_s3[1]) ? far_s3[0] : far_s3[1];
			hib_s4   <= far_s3[2];
			pmiss_s4 <= pmiss_s3;
		end
	end

	assign lo_fin = (loa_s4 > lob_s4) ? loa_s4 : lob_s4;
	assign hi_fin = (hia_s4 < hib_s4) ? hia_s4 : hib_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!pmiss_s4 && !(lo_fin > hi_fin)) begin
				hit_s5  <= 1'b1;
				near_s5 <= lo_fin;
				far_s5  <= hi_fin;
			end else begin
				hit_s5  <= 1'b0;
				near_s5 <= rbst_pkg::T_MIN;
				far_s5  <= rbst_pkg::T_MIN;
			end
		end
	end

	assign out_valid = vld_s5;
	assign hit       = hit_s5;
	assign t_near    = near_s5;
	assign t_far     = far_s5;

	// a hit always has an ordered, non-negative interval
	a_hit_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (t_near <= t_far && t_near >= 0))
		else $error("hit with bad interval");

	// a miss reports the most negative value in both parameters
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (t_near == rbst_pkg::T_MIN && t_far == rbst_pkg::T_MIN))
		else $error("miss with wrong parameters");

	// a stalled pipe moves none of the checked valid bits (stage 2, stage 3, side line end)
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_s3) && $stable(vld_s2) && $stable(vld_sd[LAT-1])))
		else $error("pipe moved during stall");

endmodule

FILE: rtl/rbst_div.sv
// ----------------------------------------------------------------------------
// rbst_div
// pipelined restoring divider, one quotient bit per stage, signed saturating
// ----------------------------------------------------------------------------
module rbst_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic [rbst_pkg::NUM_W-1:0]      num_mag,
	input  logic [rbst_pkg::QB-1:0]         den_mag,
	input  logic                            neg,
	output logic signed [rbst_pkg::W-1:0]   quo
);

	localparam int QB = rbst_pkg::QB;
	localparam logic [QB-1:0] HALF = {1'b1, {(QB-1){1'b0}}};

	logic [QB-1:0] rem_s [0:QB];
	logic [QB-1:0] low_s [0:QB];
	logic [QB-1:0] quo_s [0:QB];
	logic [QB-1:0] den_s [0:QB];
	logic          neg_s [0:QB];
	logic          ovf_s [0:QB];
	logic signed [rbst_pkg::W-1:0] q_s;

	logic          ovf_in;

	// quotient needs more than QB bits
	assign ovf_in = {{(2*QB-rbst_pkg::NUM_W){1'b0}}, num_mag} >= {den_mag, {QB{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {{(2*QB-rbst_pkg::NUM_W){1'b0}}, num_mag[rbst_pkg::NUM_W-1:QB]};
			low_s[0] <= num_mag[QB-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den_mag;
			neg_s[0] <= neg;
			ovf_s[0] <= ovf_in;
		end
	end

	for (genvar i = 1; i <= QB; i++) begin : g_step
		logic [QB:0] trial;
		logic        ge;
		assign trial = {rem_s[i-1], low_s[i-1][QB-1]};
		assign ge    = trial >= {1'b0, den_s[i-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? QB'(trial - {1'b0, den_s[i-1]}) : trial[QB-1:0];
				low_s[i] <= {low_s[i-1][QB-2:0], 1'b0};
				quo_s[i] <= {quo_s[i-1][QB-2:0], ge};
				den_s[i] <= den_s[i-1];
				neg_s[i] <= neg_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
			end
		end
	end

	// apply sign, saturate to the signed range
	always_ff @(posedge clk) begin
		if (en) begin
			if (!neg_s[QB]) begin
				q_s <= (ovf_s[QB] || quo_s[QB][QB-1]) ? rbst_pkg::T_MAX : quo_s[QB];
			end else begin
				q_s <= (ovf_s[QB] || (quo_s[QB] > HALF)) ? rbst_pkg::T_MIN : -quo_s[QB];
			end
		end
	end

	assign quo = q_s;

endmodule
